// File: rtl/idpr_pkg.sv
package idpr_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 4;
    localparam int MAX_LANES   = 32;
    localparam int GROUP_LANES = 8;
    localparam int PROD_W      = 2 * BYTE_W;
    localparam int ACC_W       = 32;
    localparam int RQ_SHIFT    = 6;
    localparam int RQ_ROUND    = 32;
    localparam int OUT_MAX     = 127;
    localparam int OUT_MIN     = -128;
    localparam int QUEUE_DEPTH = 4;

    // activation words then weight words
    localparam int S_TDATA_W   = 2 * NUM_WORDS * WORD_W;
    localparam int M_TDATA_W   = BYTE_W;

    typedef struct packed {
        logic last;
        logic relu;
    } idpr_flags_t;

endpackage

// File: rtl/idpr_front.sv
module idpr_front #(
    parameter int LANES = 32,
    parameter int DOT_W = 21
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [idpr_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    input  logic                               s_tuser,
    output logic                               dot_valid,
    input  logic                               dot_ready,
    output logic signed [DOT_W-1:0]            dot_sum,
    output idpr_pkg::idpr_flags_t              dot_flags
);
    import idpr_pkg::*;

    localparam int GROUPS = (LANES + GROUP_LANES - 1) / GROUP_LANES;
    localparam int NPROD  = GROUPS * GROUP_LANES;
    localparam int GRP_W  = PROD_W + $clog2(GROUP_LANES);
    localparam int LANE_BITS = MAX_LANES * BYTE_W;

    logic signed [BYTE_W-1:0] act_lane [NPROD];
    logic signed [BYTE_W-1:0] wgt_lane [NPROD];

    logic signed [PROD_W-1:0] prod_reg  [NPROD];
    logic signed [PROD_W-1:0] prod_next [NPROD];
    logic signed [GRP_W-1:0]  grp_reg   [GROUPS];
    logic signed [GRP_W-1:0]  grp_next  [GROUPS];
    logic signed [DOT_W-1:0]  dot_reg;
    logic signed [DOT_W-1:0]  dot_next;

    logic        v1_reg, v2_reg, v3_reg;
    idpr_flags_t flags1_reg, flags2_reg, flags3_reg;
    logic        adv1, adv2, adv3;

    // pipeline moves forward wherever the next stage has room
    assign adv3     = !v3_reg || dot_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_comb begin
        for (int k = 0; k < NPROD; k++) begin
            act_lane[k] = s_tdata[k*BYTE_W +: BYTE_W];
            wgt_lane[k] = s_tdata[LANE_BITS + k*BYTE_W +: BYTE_W];
            if (k < LANES) begin
                prod_next[k] = act_lane[k] * wgt_lane[k];
            end else begin
                prod_next[k] = '0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP_LANES; j++) begin
                grp_next[g] = grp_next[g] + GRP_W'(prod_reg[g*GROUP_LANES + j]);
            end
        end
    end

    always_comb begin
        dot_next = '0;
        for (int g = 0; g < GROUPS; g++) begin
            dot_next = dot_next + DOT_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_tvalid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && s_tvalid) begin
            prod_reg        <= prod_next;
            flags1_reg.last <= s_tlast;
            flags1_reg.relu <= s_tuser;
        end
        if (adv2 && v1_reg) begin
            grp_reg    <= grp_next;
            flags2_reg <= flags1_reg;
        end
        if (adv3 && v2_reg) begin
            dot_reg    <= dot_next;
            flags3_reg <= flags2_reg;
        end
    end

    assign dot_valid = v3_reg;
    assign dot_sum   = dot_reg;
    assign dot_flags = flags3_reg;

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !dot_ready))
        else $error("front stalled with a free stage");

endmodule

// File: rtl/idpr_fifo.sv
module idpr_fifo #(
    parameter int DATA_W = 23,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

// File: rtl/idpr_back.sv
module idpr_back #(
    parameter int DOT_W = 21
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  logic signed [DOT_W-1:0]          q_dot,
    input  idpr_pkg::idpr_flags_t            q_flags,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [idpr_pkg::M_TDATA_W-1:0]   m_tdata
);
    import idpr_pkg::*;

    localparam int RND_W = ACC_W + 1;
    localparam logic signed [RND_W-1:0] RND_ADD = RND_W'(RQ_ROUND);
    localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(OUT_MAX);
    localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(OUT_MIN);

    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        total;
    logic                    r1_v_reg;
    logic [ACC_W-1:0]        r1_total_reg;
    logic                    r1_relu_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic [M_TDATA_W-1:0]    m_tdata_next;
    logic signed [RND_W-1:0] rounded;
    logic signed [RND_W-1:0] scaled;
    logic                    out_adv, r1_adv, pop;

    assign out_adv = !m_tvalid_reg || m_tready;
    assign r1_adv  = !r1_v_reg || out_adv;
    // a closing entry waits for room in the requant stage; others go straight in
    assign q_ready = !q_flags.last || r1_adv;
    assign pop     = q_valid && q_ready;

    assign total = acc_reg + ACC_W'(q_dot);

    always_comb begin
        rounded = $signed({r1_total_reg[ACC_W-1], r1_total_reg}) + RND_ADD;
        scaled  = rounded >>> RQ_SHIFT;
        if (r1_relu_reg) begin
            if (scaled <= 0) begin
                m_tdata_next = '0;
            end else if (scaled > RND_MAX) begin
                m_tdata_next = M_TDATA_W'(OUT_MAX);
            end else begin
                m_tdata_next = scaled[M_TDATA_W-1:0];
            end
        end else begin
            if (scaled > RND_MAX) begin
                m_tdata_next = M_TDATA_W'(OUT_MAX);
            end else if (scaled < RND_MIN) begin
                m_tdata_next = M_TDATA_W'(OUT_MIN);
            end else begin
                m_tdata_next = scaled[M_TDATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            r1_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (pop) begin
                acc_reg <= q_flags.last ? '0 : total;
            end
            if (r1_adv) begin
                r1_v_reg <= pop && q_flags.last;
            end
            if (out_adv) begin
                m_tvalid_reg <= r1_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1_adv && pop && q_flags.last) begin
            r1_total_reg <= total;
            r1_relu_reg  <= q_flags.relu;
        end
        if (out_adv && r1_v_reg) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_flags.last) |=> (acc_reg == '0))
        else $error("accumulator not cleared after closing chunk");

    a_requant_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (r1_v_reg && !out_adv) |=> (r1_v_reg && $stable(r1_total_reg)))
        else $error("requant stage dropped a pending total");

endmodule

// File: rtl/int8_dot_product_requant_unit.sv
// channel  dir  tdata                                   tuser        tlast
// s_       in   act words 0..3 then wgt words 0..3      apply_relu   last_chunk
// m_       out  neuron_value (8b signed)                -            -
//
// One chunk per cycle while the queue has room; the multiply, group-sum and
// final-sum stages are each registered, then a 4-entry queue feeds the accumulator.
// A closing chunk then passes through a requant register and an output register.
// aresetn (synchronous) clears the accumulator and drops any partial neuron.
// A stall on m_ holds the output register; the queue keeps s_ moving until full.
module int8_dot_product_requant_unit #(
    parameter int LANES = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // act_word0, act_word1, act_word2, act_word3, wgt_word0, wgt_word1, wgt_word2, wgt_word3
    input  logic [idpr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    // apply_relu
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // neuron_value
    output logic [idpr_pkg::M_TDATA_W-1:0]   m_tdata
);
    import idpr_pkg::*;

    localparam int GROUPS = (LANES + GROUP_LANES - 1) / GROUP_LANES;
    localparam int DOT_W  = PROD_W + $clog2(GROUP_LANES) + $clog2(GROUPS);
    localparam int FLG_W  = $bits(idpr_flags_t);
    localparam int Q_W    = DOT_W + FLG_W;

    logic                    dot_valid, dot_ready;
    logic signed [DOT_W-1:0] dot_sum;
    idpr_flags_t             dot_flags;
    logic                    q_valid, q_ready;
    logic [Q_W-1:0]          q_data;
    logic signed [DOT_W-1:0] q_dot;
    idpr_flags_t             q_flags;

    idpr_front #(
        .LANES (LANES),
        .DOT_W (DOT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .dot_valid (dot_valid),
        .dot_ready (dot_ready),
        .dot_sum   (dot_sum),
        .dot_flags (dot_flags)
    );

    idpr_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .in_data   ({dot_flags, dot_sum}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign q_dot   = $signed(q_data[DOT_W-1:0]);
    assign q_flags = idpr_flags_t'(q_data[Q_W-1:DOT_W]);

    idpr_back #(
        .DOT_W (DOT_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_dot    (q_dot),
        .q_flags  (q_flags),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
